// ===== sv/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is held
`define BDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication whose consequence is checked at the clock edge after the trigger
`define BDQ_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

// ===== sv/bdq_pkg.sv =====
package bdq_pkg;

  // default number of stored words
  localparam int unsigned DepthDefault = 1024;

  localparam int unsigned WordW  = 32;
  localparam int unsigned OpW    = 3;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 11;

  // operation codes of a request
  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_QUERY      = 3'd5
  } bdq_op_e;

  // result status codes
  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } bdq_status_e;

  // command broadcast to every cell of a chain
  typedef enum logic [2:0] {
    CMD_HOLD   = 3'd0,
    CMD_CLEAR  = 3'd1,
    CMD_SHR    = 3'd2,
    CMD_SHL    = 3'd3,
    CMD_FILL_L = 3'd4,
    CMD_FILL_R = 3'd5,
    CMD_DROP_L = 3'd6,
    CMD_DROP_R = 3'd7
  } bdq_cmd_e;

  // one cell's content as seen by its neighbors
  typedef struct packed {
    logic             occ;
    logic [WordW-1:0] data;
  } bdq_link_t;

  // request payload
  typedef struct packed {
    logic        [OpW-1:0]   op;
    logic signed [WordW-1:0] value;
  } bdq_req_t;

  // result payload
  typedef struct packed {
    logic        [StatW-1:0]  status;
    logic signed [WordW-1:0]  popped;
    logic signed [WordW-1:0]  front_value;
    logic signed [WordW-1:0]  back_value;
    logic        [CountW-1:0] count;
  } bdq_res_t;

endpackage

// ===== sv/bdq_cell.sv =====
module bdq_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bdq_pkg::bdq_cmd_e            cmd_i,
  input  logic [bdq_pkg::WordW-1:0]    word_i,
  input  bdq_pkg::bdq_link_t           left_i,
  input  bdq_pkg::bdq_link_t           right_i,
  output bdq_pkg::bdq_link_t           cell_o
);

  logic                      occ_q, occ_d;
  logic [bdq_pkg::WordW-1:0] data_q, data_d;

  // local update from the broadcast command and the two neighbors
  always_comb begin
    occ_d  = occ_q;
    data_d = data_q;
    case (cmd_i)
      bdq_pkg::CMD_HOLD: begin
      end
      bdq_pkg::CMD_CLEAR: begin
        occ_d = 1'b0;
      end
      bdq_pkg::CMD_SHR: begin
        occ_d  = left_i.occ;
        data_d = left_i.data;
      end
      bdq_pkg::CMD_SHL: begin
        occ_d  = right_i.occ;
        data_d = right_i.data;
      end
      // empty cell just left of the occupied run takes the word
      bdq_pkg::CMD_FILL_L: begin
        if (!occ_q && right_i.occ) begin
          occ_d  = 1'b1;
          data_d = word_i;
        end
      end
      // empty cell just right of the occupied run takes the word
      bdq_pkg::CMD_FILL_R: begin
        if (!occ_q && left_i.occ) begin
          occ_d  = 1'b1;
          data_d = word_i;
        end
      end
      // leftmost occupied cell lets go
      bdq_pkg::CMD_DROP_L: begin
        if (occ_q && !left_i.occ) begin
          occ_d = 1'b0;
        end
      end
      // rightmost occupied cell lets go
      bdq_pkg::CMD_DROP_R: begin
        if (occ_q && !right_i.occ) begin
          occ_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // stored word
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign cell_o.occ  = occ_q;
  assign cell_o.data = data_q;

endmodule

// ===== sv/bdq_chain.sv =====
module bdq_chain #(
  parameter int unsigned DEPTH = bdq_pkg::DepthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bdq_pkg::bdq_cmd_e         cmd_i,
  input  logic [bdq_pkg::WordW-1:0] word_i,
  input  bdq_pkg::bdq_link_t        left_tie_i,
  input  bdq_pkg::bdq_link_t        right_tie_i,
  output bdq_pkg::bdq_link_t        lo_o,
  output bdq_pkg::bdq_link_t        hi_o
);

  bdq_pkg::bdq_link_t cells [DEPTH];

  // row of cells, each wired to its two neighbors or to the end ties
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bdq_pkg::bdq_link_t left_w, right_w;

    if (i == 0) begin : g_lo
      assign left_w = left_tie_i;
    end else begin : g_mid_l
      assign left_w = cells[i-1];
    end

    if (i == DEPTH - 1) begin : g_hi
      assign right_w = right_tie_i;
    end else begin : g_mid_r
      assign right_w = cells[i+1];
    end

    bdq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd_i),
      .word_i  (word_i),
      .left_i  (left_w),
      .right_i (right_w),
      .cell_o  (cells[i])
    );
  end

  assign lo_o = cells[0];
  assign hi_o = cells[DEPTH-1];

endmodule

// ===== sv/bounded_deque_engine.sv =====
// Bounded double-ended queue of signed 32-bit words. A request is taken whenever
// start is high; busy stays low, so one request can be issued every cycle. The
// result comes back exactly one cycle after the request, with done_o high for
// that single cycle, and must be captured then: it is not held. The words live
// in two identical rows of DEPTH cells that shift or fill in one step, one row
// packed toward the front and one toward the back, so both ends sit at fixed
// cells and every operation finishes in the cycle it is taken. A push into a
// full queue reports a full error and a pop from an empty one an empty error;
// neither changes the contents. Clear empties the queue in one cycle.
module bounded_deque_engine #(
  parameter int unsigned DEPTH = bdq_pkg::DepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  bdq_pkg::bdq_req_t req_i,
  output logic              done_o,
  output bdq_pkg::bdq_res_t res_o
);

  localparam int unsigned FillW = $clog2(DEPTH + 1);

  bdq_pkg::bdq_cmd_e  l_cmd, r_cmd;
  bdq_pkg::bdq_link_t l_lo, l_hi, r_lo, r_hi;
  bdq_pkg::bdq_link_t word_tie, null_tie;

  logic [FillW-1:0]          fill_q, fill_d;
  logic                      done_q;
  logic [bdq_pkg::StatW-1:0] status_q, status_d;
  logic [bdq_pkg::WordW-1:0] popped_q, popped_d;
  logic                      accept;
  logic                      full_w, empty_w;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // both rows agree on occupancy, so either end tells full or empty
  assign full_w  = l_hi.occ && r_lo.occ;
  assign empty_w = !l_lo.occ;

  assign word_tie.occ  = 1'b1;
  assign word_tie.data = req_i.value;
  assign null_tie.occ  = 1'b0;
  assign null_tie.data = '0;

  // front-packed row: cell 0 is the front word
  bdq_chain #(.DEPTH(DEPTH)) u_front_row (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (l_cmd),
    .word_i      (req_i.value),
    .left_tie_i  (word_tie),
    .right_tie_i (null_tie),
    .lo_o        (l_lo),
    .hi_o        (l_hi)
  );

  // back-packed row: the last cell is the back word
  bdq_chain #(.DEPTH(DEPTH)) u_back_row (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (r_cmd),
    .word_i      (req_i.value),
    .left_tie_i  (null_tie),
    .right_tie_i (word_tie),
    .lo_o        (r_lo),
    .hi_o        (r_hi)
  );

  // decode the request into row commands, status and count update
  always_comb begin
    l_cmd    = bdq_pkg::CMD_HOLD;
    r_cmd    = bdq_pkg::CMD_HOLD;
    status_d = bdq_pkg::ST_OK;
    popped_d = '0;
    fill_d   = fill_q;
    if (accept) begin
      case (req_i.op)
        bdq_pkg::OP_PUSH_FRONT: begin
          if (full_w) begin
            status_d = bdq_pkg::ST_FULL;
          end else begin
            l_cmd  = bdq_pkg::CMD_SHR;
            r_cmd  = bdq_pkg::CMD_FILL_L;
            fill_d = fill_q + FillW'(1);
          end
        end
        bdq_pkg::OP_PUSH_BACK: begin
          if (full_w) begin
            status_d = bdq_pkg::ST_FULL;
          end else begin
            l_cmd  = bdq_pkg::CMD_FILL_R;
            r_cmd  = bdq_pkg::CMD_SHL;
            fill_d = fill_q + FillW'(1);
          end
        end
        bdq_pkg::OP_POP_FRONT: begin
          if (empty_w) begin
            status_d = bdq_pkg::ST_EMPTY;
          end else begin
            popped_d = l_lo.data;
            l_cmd    = bdq_pkg::CMD_SHL;
            r_cmd    = bdq_pkg::CMD_DROP_L;
            fill_d   = fill_q - FillW'(1);
          end
        end
        bdq_pkg::OP_POP_BACK: begin
          if (empty_w) begin
            status_d = bdq_pkg::ST_EMPTY;
          end else begin
            popped_d = r_hi.data;
            l_cmd    = bdq_pkg::CMD_DROP_R;
            r_cmd    = bdq_pkg::CMD_SHR;
            fill_d   = fill_q - FillW'(1);
          end
        end
        bdq_pkg::OP_CLEAR: begin
          l_cmd  = bdq_pkg::CMD_CLEAR;
          r_cmd  = bdq_pkg::CMD_CLEAR;
          fill_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      done_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      done_q <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    popped_q <= popped_d;
  end

  // ends of the rows already reflect the request being answered
  assign done_o            = done_q;
  assign res_o.status      = status_q;
  assign res_o.popped      = popped_q;
  assign res_o.front_value = l_lo.occ ? l_lo.data : '0;
  assign res_o.back_value  = r_hi.occ ? r_hi.data : '0;
  assign res_o.count       = bdq_pkg::CountW'(fill_q);

endmodule

// ===== sv/bdq_checker.sv =====
`include "assert_macros.svh"

module bdq_checker #(
  parameter int unsigned DEPTH = bdq_pkg::DepthDefault
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input bdq_pkg::bdq_res_t res_o
);

  logic req_taken;
  logic st_empty, st_full;
  logic empty_res;

  assign req_taken = start && !busy;
  assign st_empty  = done_o && (res_o.status == bdq_pkg::ST_EMPTY);
  assign st_full   = done_o && (res_o.status == bdq_pkg::ST_FULL);
  assign empty_res = done_o && (res_o.count == '0);

  // every request gets its result in the next cycle
  `BDQ_ASSERT_NEXT(a_result_follows, req_taken, done_o, "request without result")

  // no result without a request
  `BDQ_ASSERT_NEXT(a_no_spurious, !req_taken, !done_o, "result without request")

  // an empty error leaves an empty queue and pops nothing
  `BDQ_ASSERT(a_empty_err, st_empty |-> (res_o.count == '0 && res_o.popped == '0), "bad empty")

  // a full error only with the queue at capacity
  `BDQ_ASSERT(a_full_err, st_full |-> (res_o.count == bdq_pkg::CountW'(DEPTH)), "bad full")

  // an empty queue shows no front or back word
  `BDQ_ASSERT(a_empty_ends, empty_res |-> (res_o.front_value == '0 && res_o.back_value == '0), "empty ends")

endmodule

bind bounded_deque_engine bdq_checker #(.DEPTH(DEPTH)) u_bdq_checker (.*);

// ===== sim/testbench.sv =====
module testbench;
  import bdq_pkg::*;

  localparam int unsigned DEPTH = DepthDefault;

  // op codes the block treats as a query
  localparam logic [OpW-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OpW-1:0] OP_SPARE_HI = 3'd7;

  // window of sent requests with no idle cycles on the request side
  localparam int QuietLo = 300;
  localparam int QuietHi = 650;

  localparam int IdlePct = 27;
  localparam int LimitCycles = 100000;

  typedef struct {
    bdq_req_t req;
    bit       drain;
  } pending_op_t;

  logic     clk_i;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  bdq_req_t req = '0;
  logic     done;
  bdq_res_t res;

  pending_op_t pending_ops[$];
  bdq_res_t    expected_results[$];
  int          ops_sent = 0;
  int          mismatches = 0;

  // shadow deque state
  logic [WordW-1:0] dq_mem [DEPTH];
  int unsigned      dq_head = 0;
  int unsigned      dq_fill = 0;

  // fill level as tracked by the request generator
  int unsigned gen_fill = 0;

  bounded_deque_engine #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req),
    .done_o(done),
    .res_o (res)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // apply one request to the shadow deque and return the result it must give
  function automatic bdq_res_t deque_apply(bdq_req_t r);
    bdq_res_t o;
    o = '0;
    o.status = ST_OK;
    case (r.op)
      OP_PUSH_FRONT: begin
        if (dq_fill >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          dq_head = (dq_head + DEPTH - 1) % DEPTH;
          dq_mem[dq_head] = r.value;
          dq_fill++;
        end
      end
      OP_PUSH_BACK: begin
        if (dq_fill >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          dq_mem[(dq_head + dq_fill) % DEPTH] = r.value;
          dq_fill++;
        end
      end
      OP_POP_FRONT: begin
        if (dq_fill == 0) begin
          o.status = ST_EMPTY;
        end else begin
          o.popped = dq_mem[dq_head];
          dq_head = (dq_head + 1) % DEPTH;
          dq_fill--;
        end
      end
      OP_POP_BACK: begin
        if (dq_fill == 0) begin
          o.status = ST_EMPTY;
        end else begin
          o.popped = dq_mem[(dq_head + dq_fill - 1) % DEPTH];
          dq_fill--;
        end
      end
      OP_CLEAR: begin
        dq_head = 0;
        dq_fill = 0;
      end
      default: begin
      end
    endcase
    if (dq_fill != 0) begin
      o.front_value = dq_mem[dq_head];
      o.back_value  = dq_mem[(dq_head + dq_fill - 1) % DEPTH];
    end
    o.count = CountW'(dq_fill);
    return o;
  endfunction

  // queue one request and follow the fill level it leads to
  task automatic add_op(input logic [OpW-1:0] op, input logic [WordW-1:0] value,
                        input bit drain);
    pending_op_t p;
    p.req.op    = op;
    p.req.value = value;
    p.drain     = drain;
    pending_ops = {pending_ops, p};
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: if (gen_fill < DEPTH) gen_fill++;
      OP_POP_FRONT, OP_POP_BACK:   if (gen_fill > 0) gen_fill--;
      OP_CLEAR:                    gen_fill = 0;
      default: begin
      end
    endcase
  endtask

  // random word, with the extremes now and then
  function automatic logic [WordW-1:0] rand_word();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // random op code with the given mix of pushes, pops and clears
  function automatic logic [OpW-1:0] pick_op(int push_pct, int pop_pct, int clear_pct);
    int r;
    r = $urandom_range(99);
    if (r < push_pct) return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    if (r < push_pct + pop_pct) return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
    if (r < push_pct + pop_pct + clear_pct) return OP_CLEAR;
    case ($urandom_range(2))
      0:       return OP_QUERY;
      1:       return OP_SPARE_LO;
      default: return OP_SPARE_HI;
    endcase
  endfunction

  // request driver
  always @(posedge clk_i) begin : drive
    pending_op_t nxt;
    logic        go;
    if (rst_ni) begin
      if (start && !busy) begin
        expected_results = {expected_results, deque_apply(req)};
        ops_sent++;
      end
      if (!start || !busy) begin
        go = 1'b0;
        if (pending_ops.size() != 0) begin
          go = 1'b1;
          if (pending_ops[0].drain && expected_results.size() != 0) begin
            go = 1'b0;
          end else if (!(ops_sent >= QuietLo && ops_sent < QuietHi) &&
                       $urandom_range(99) < IdlePct) begin
            go = 1'b0;
          end
        end
        if (go) begin
          nxt = pending_ops[0];
          pending_ops.delete(0);
          req <= nxt.req;
        end
        start <= go;
      end
    end
  end

  task automatic report_field(input string name, input logic [WordW-1:0] exp_v,
                              input logic [WordW-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // result monitor
  always @(posedge clk_i) begin : watch
    bdq_res_t exp_r;
    if (rst_ni && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request pending, expected none, got %h", $time, res);
        mismatches++;
      end else begin
        exp_r = expected_results[0];
        expected_results.delete(0);
        report_field("status", WordW'(exp_r.status), WordW'(res.status));
        report_field("popped", exp_r.popped, res.popped);
        report_field("front_value", exp_r.front_value, res.front_value);
        report_field("back_value", exp_r.back_value, res.back_value);
        report_field("count", WordW'(exp_r.count), WordW'(res.count));
      end
    end
  end

  // stimulus and end of run
  initial begin
    // directed: empty pops, spare codes, extremes at both ends, clear
    add_op(OP_POP_FRONT, rand_word(), 1'b0);
    add_op(OP_POP_BACK, rand_word(), 1'b0);
    add_op(OP_QUERY, rand_word(), 1'b0);
    add_op(OP_SPARE_LO, rand_word(), 1'b0);
    add_op(OP_SPARE_HI, rand_word(), 1'b0);
    add_op(OP_PUSH_FRONT, 32'h8000_0000, 1'b0);
    add_op(OP_PUSH_BACK, 32'h7fff_ffff, 1'b0);
    add_op(OP_PUSH_FRONT, 32'hffff_ffff, 1'b0);
    add_op(OP_PUSH_BACK, 32'h0000_0000, 1'b0);
    add_op(OP_QUERY, rand_word(), 1'b0);
    add_op(OP_POP_BACK, rand_word(), 1'b0);
    add_op(OP_POP_FRONT, rand_word(), 1'b0);
    add_op(OP_POP_FRONT, rand_word(), 1'b0);
    add_op(OP_POP_BACK, rand_word(), 1'b0);
    add_op(OP_POP_BACK, rand_word(), 1'b0);
    add_op(OP_PUSH_BACK, 32'h5555_5555, 1'b0);
    add_op(OP_PUSH_FRONT, 32'haaaa_aaaa, 1'b0);
    add_op(OP_CLEAR, rand_word(), 1'b0);
    add_op(OP_QUERY, rand_word(), 1'b0);
    add_op(OP_POP_FRONT, rand_word(), 1'b0);
    add_op(OP_PUSH_FRONT, 32'h0000_0001, 1'b0);
    add_op(OP_POP_BACK, rand_word(), 1'b0);
    add_op(OP_CLEAR, rand_word(), 1'b0);

    // mostly pushes until the deque is full
    add_op(OP_PUSH_BACK, rand_word(), 1'b1);
    while (gen_fill < DEPTH) add_op(pick_op(93, 4, 0), rand_word(), 1'b0);

    // churn around full, with pushes refused whenever it is full
    add_op(OP_PUSH_FRONT, rand_word(), 1'b1);
    repeat (60) add_op(pick_op(50, 35, 0), rand_word(), 1'b0);

    // clear from deep, then a mix at low fill with empty pops
    add_op(OP_CLEAR, rand_word(), 1'b1);
    repeat (260) add_op(pick_op(42, 40, 4), rand_word(), 1'b0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || start) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #(12 * LimitCycles);
    $display("testbench: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/bdq_pkg.sv
sv/bdq_cell.sv
sv/bdq_chain.sv
sv/bounded_deque_engine.sv
sv/bdq_checker.sv
sim/testbench.sv
